@@ design/jctm_pkg.sv @@
// ----------------------------------------------------------------------------
// jctm_pkg
// Shared types, constants and helper functions of the joystick cursor and
// touch mapper.
// ----------------------------------------------------------------------------
package jctm_pkg;

   localparam int MAX_SCREEN_DIM = 4096;
   localparam int DIM_W          = 13;
   localparam int COORD_W        = 12;
   localparam int AXIS_W         = 16;
   localparam int MAG_W          = AXIS_W + 1;
   localparam int DEADZONE_W     = 16;
   localparam int STEP_W         = 12;
   localparam int CSR_DATA_W     = 16;
   localparam int POS_W          = 15;
   localparam int SSTEP_W        = 4;

   localparam logic [DIM_W-1:0]      DEFAULT_W        = 13'd960;
   localparam logic [DIM_W-1:0]      DEFAULT_H        = 13'd540;
   localparam logic [DIM_W-1:0]      MAX_DIM          = 13'(MAX_SCREEN_DIM);
   localparam logic [DEADZONE_W-1:0] DEFAULT_DEADZONE = 16'd8000;
   localparam logic [STEP_W-1:0]     DEFAULT_STEP     = 12'd56;
   localparam logic [COORD_W-1:0]    RESET_COL        = 12'd480;
   localparam logic [COORD_W-1:0]    RESET_ROW        = 12'd270;

   // Full-scale axis value squared.
   localparam longint AXIS_FULL_SQ = 64'd32767 * 64'd32767;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_DEADZONE      = 2'd2,
      CSR_DPAD_STEP     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_TOUCH_DOWN   = 3'd1,
      EV_TOUCH_MOVE   = 3'd2,
      EV_TOUCH_UP     = 3'd3,
      EV_BACK_PRESS   = 3'd4,
      EV_BACK_RELEASE = 3'd5,
      EV_MENU_PRESS   = 3'd6,
      EV_MENU_RELEASE = 3'd7
   } event_kind_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] stick_x;
      logic signed [AXIS_W-1:0] stick_y;
      logic [3:0]               dpad_bits;
      logic                     button_a;
      logic                     button_b;
      logic                     button_start;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic               last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] cursor_col;
      logic [COORD_W-1:0] cursor_row;
      logic [3:0]         prev_dpad;
      logic               touching;
      logic [COORD_W-1:0] last_move_col;
      logic [COORD_W-1:0] last_move_row;
      logic               prev_back;
      logic               prev_menu;
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]      eff_width;
      logic [DIM_W-1:0]      eff_height;
      logic [DEADZONE_W-1:0] deadzone;
      logic [STEP_W-1:0]     dpad_step;
   } cfg_type;

   // Events of one tick, oldest in slot 0, plus how many are left.
   typedef struct packed {
      logic [2:0][2:0]    kinds;
      logic [1:0]         count;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } grp_type;

   // Effective screen dimension: zero takes the default, large values clip.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] dflt);
      logic [DIM_W-1:0] r;
      r = (v == '0) ? dflt : v;
      if (r > MAX_DIM) r = MAX_DIM;
      return r;
   endfunction

   // Smallest magnitude m with 8*m*m >= t*AXIS_FULL_SQ. Used for constants.
   function automatic logic [MAG_W-1:0] min_mag(input longint t);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 65536;
      for (int i = 0; i < 20; i++) begin
         mid = (lo + hi) >> 1;
         if (lo < hi) begin
            if (64'd8 * mid * mid >= t * AXIS_FULL_SQ) hi = mid;
            else lo = mid + 1;
         end
      end
      return MAG_W'(lo);
   endfunction

   // Magnitude thresholds: odd multiples 1..9 of the half step.
   localparam logic [MAG_W-1:0] THR_1 = min_mag(1);
   localparam logic [MAG_W-1:0] THR_3 = min_mag(3);
   localparam logic [MAG_W-1:0] THR_5 = min_mag(5);
   localparam logic [MAG_W-1:0] THR_7 = min_mag(7);
   localparam logic [MAG_W-1:0] THR_9 = min_mag(9);

endpackage

@@ design/jctm_axis.sv @@
// ----------------------------------------------------------------------------
// jctm_axis
// Quadratic stick step for one axis, with deadzone, as a signed step -3..4.
// ----------------------------------------------------------------------------
module jctm_axis
   import jctm_pkg::*;
(
   input  logic signed [AXIS_W-1:0]     axis,
   input  logic        [DEADZONE_W-1:0] deadzone,
   output logic signed [SSTEP_W-1:0]    step
);

   logic [MAG_W-1:0]   mag;
   logic [2:0]         cnt_pos;
   logic [2:0]         cnt_neg;
   logic               active;

   always_comb begin
      mag = axis[AXIS_W-1] ? ((~{axis[AXIS_W-1], axis}) + MAG_W'(1))
                           : {1'b0, axis};
      active = (mag != '0) && (mag >= {1'b0, deadzone});
      // The step is the number of half-step thresholds the square crosses;
      // the positive side rounds half up, the negative side counts from THR_3.
      cnt_pos = 3'(mag >= THR_1) + 3'(mag >= THR_3) + 3'(mag >= THR_5)
              + 3'(mag >= THR_7);
      cnt_neg = 3'(mag >= THR_3) + 3'(mag >= THR_5) + 3'(mag >= THR_7)
              + 3'(mag >= THR_9);
      if (!active) begin
         step = '0;
      end else if (axis[AXIS_W-1]) begin
         step = -$signed({1'b0, cnt_neg});
      end else begin
         step = $signed({1'b0, cnt_pos});
      end
   end

endmodule

@@ design/jctm_tick.sv @@
// ----------------------------------------------------------------------------
// jctm_tick
// One controller poll: new cursor, new state and the ordered event list.
// ----------------------------------------------------------------------------
module jctm_tick
   import jctm_pkg::*;
(
   input  req_type   item,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output grp_type   grp
);

   logic signed [SSTEP_W-1:0] step_x;
   logic signed [SSTEP_W-1:0] step_y;
   logic [3:0]                rise;
   logic signed [POS_W-1:0]   px;
   logic signed [POS_W-1:0]   py;
   logic signed [POS_W-1:0]   dstep;
   logic signed [POS_W-1:0]   lim_x;
   logic signed [POS_W-1:0]   lim_y;
   logic [COORD_W-1:0]        cx;
   logic [COORD_W-1:0]        cy;
   logic [1:0]                n;

   jctm_axis u_axis_x (
      .axis     (item.stick_x),
      .deadzone (cfg.deadzone),
      .step     (step_x)
   );

   jctm_axis u_axis_y (
      .axis     (item.stick_y),
      .deadzone (cfg.deadzone),
      .step     (step_y)
   );

   always_comb begin
      rise  = item.dpad_bits & ~cur.prev_dpad;
      dstep = $signed({3'b000, cfg.dpad_step});
      lim_x = $signed({2'b00, cfg.eff_width});
      lim_y = $signed({2'b00, cfg.eff_height});

      px = $signed({3'b000, cur.cursor_col}) + {{(POS_W-SSTEP_W){step_x[SSTEP_W-1]}}, step_x};
      py = $signed({3'b000, cur.cursor_row}) + {{(POS_W-SSTEP_W){step_y[SSTEP_W-1]}}, step_y};
      if (rise[0]) py = py - dstep;
      if (rise[1]) py = py + dstep;
      if (rise[2]) px = px - dstep;
      if (rise[3]) px = px + dstep;

      if (px < 0)           cx = '0;
      else if (px >= lim_x) cx = COORD_W'(cfg.eff_width - DIM_W'(1));
      else                  cx = px[COORD_W-1:0];
      if (py < 0)           cy = '0;
      else if (py >= lim_y) cy = COORD_W'(cfg.eff_height - DIM_W'(1));
      else                  cy = py[COORD_W-1:0];

      nxt            = cur;
      nxt.cursor_col = cx;
      nxt.cursor_row = cy;
      nxt.prev_dpad  = item.dpad_bits;
      nxt.prev_back  = item.button_b;
      nxt.prev_menu  = item.button_start;

      grp.kinds = '0;
      grp.col   = cx;
      grp.row   = cy;
      n         = '0;

      // Touch first, then back, then menu.
      if (item.button_a && !cur.touching) begin
         nxt.touching = 1'b1;
         grp.kinds[n] = EV_TOUCH_DOWN;
         n            = n + 2'd1;
      end else if (item.button_a && cur.touching) begin
         if (cx != cur.last_move_col || cy != cur.last_move_row) begin
            nxt.last_move_col = cx;
            nxt.last_move_row = cy;
            grp.kinds[n]      = EV_TOUCH_MOVE;
            n                 = n + 2'd1;
         end
      end else if (!item.button_a && cur.touching) begin
         nxt.touching = 1'b0;
         grp.kinds[n] = EV_TOUCH_UP;
         n            = n + 2'd1;
      end

      if (item.button_b != cur.prev_back) begin
         grp.kinds[n] = item.button_b ? EV_BACK_PRESS : EV_BACK_RELEASE;
         n            = n + 2'd1;
      end

      if (item.button_start != cur.prev_menu) begin
         grp.kinds[n] = item.button_start ? EV_MENU_PRESS : EV_MENU_RELEASE;
         n            = n + 2'd1;
      end

      if (n == 2'd0) begin
         grp.kinds[0] = EV_NONE;
         n            = 2'd1;
      end
      grp.count = n;
   end

endmodule

@@ design/joystick_cursor_touch_mapper.sv @@
// ----------------------------------------------------------------------------
// joystick_cursor_touch_mapper
// Maps controller polls to a clamped screen cursor plus touch and key events.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel is one controller poll (stick
// axes, d-pad bits and three buttons). Every poll produces one to three
// transfers on the rsp_ channel, each carrying an event code and the cursor
// after that poll; the final transfer of a poll has last_of_tick set. A poll
// with no event still yields one transfer with the "none" code.
// An accepted poll is held in the input register, moves into the result
// register once that register is free, and its first result is shown
// from then on.
// Throughput: one result per cycle while rsp_stall is low; the result
// register drains one event per transfer and that sets the rate. The input
// register takes the next poll while results still wait.
// Stalls: while rsp_stall is high the shown result holds; once the input
// register is also full, req_stall rises. Synchronous reset empties both
// registers, restores the power-up register values and centers the cursor.
// Writes to the width or height register recenter the cursor.
// ----------------------------------------------------------------------------
module joystick_cursor_touch_mapper
   import jctm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers as written.
   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;
   logic [DEADZONE_W-1:0] deadzone_ff;
   logic [STEP_W-1:0]     dpad_step_ff;

   // Cursor and edge-detect state.
   state_type state_ff;
   state_type state_in;

   // Input register and result register.
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    grp_valid_ff;
   grp_type grp_ff;
   grp_type grp_in;

   cfg_type          cfg;
   logic             take;
   logic             grp_free;
   logic             move;
   logic             accept;
   logic [DIM_W-1:0] new_w;
   logic [DIM_W-1:0] new_h;

   always_comb begin
      cfg.eff_width  = eff_dim(width_ff, DEFAULT_W);
      cfg.eff_height = eff_dim(height_ff, DEFAULT_H);
      cfg.deadzone   = deadzone_ff;
      cfg.dpad_step  = dpad_step_ff;
   end

   jctm_tick u_tick (
      .item (in_data_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .grp  (grp_in)
   );

   // The result register frees up when it is empty or its last event leaves.
   assign take      = grp_valid_ff && !rsp_stall;
   assign grp_free  = !grp_valid_ff || (take && (grp_ff.count == 2'd1));
   assign move      = in_valid_ff && grp_free;
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid             = grp_valid_ff;
   assign rsp_data.event_kind   = grp_ff.kinds[0];
   assign rsp_data.cursor_x     = grp_ff.col;
   assign rsp_data.cursor_y     = grp_ff.row;
   assign rsp_data.last_of_tick = (grp_ff.count == 2'd1);

   // Effective dimensions as they stand after a size write, for recentering.
   always_comb begin
      new_w = cfg.eff_width;
      new_h = cfg.eff_height;
      if (csr_index == CSR_SCREEN_WIDTH) begin
         new_w = eff_dim(csr_data[DIM_W-1:0], DEFAULT_W);
      end
      if (csr_index == CSR_SCREEN_HEIGHT) begin
         new_h = eff_dim(csr_data[DIM_W-1:0], DEFAULT_H);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DEFAULT_W;
         height_ff    <= DEFAULT_H;
         deadzone_ff  <= DEFAULT_DEADZONE;
         dpad_step_ff <= DEFAULT_STEP;
         state_ff     <= '{cursor_col: RESET_COL, cursor_row: RESET_ROW, default: '0};
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end

         if (move) begin
            grp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (take && (grp_ff.count == 2'd1)) begin
            grp_valid_ff <= 1'b0;
         end

         // Configuration writes only while idle: user rule, not enforced.
         if (csr_we) begin
            unique case (csr_index)
               CSR_SCREEN_WIDTH: begin
                  width_ff            <= csr_data[DIM_W-1:0];
                  state_ff.cursor_col <= new_w[DIM_W-1:1];
                  state_ff.cursor_row <= new_h[DIM_W-1:1];
               end
               CSR_SCREEN_HEIGHT: begin
                  height_ff           <= csr_data[DIM_W-1:0];
                  state_ff.cursor_col <= new_w[DIM_W-1:1];
                  state_ff.cursor_row <= new_h[DIM_W-1:1];
               end
               CSR_DEADZONE:  deadzone_ff  <= csr_data[DEADZONE_W-1:0];
               CSR_DPAD_STEP: dpad_step_ff <= csr_data[STEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         grp_ff <= grp_in;
      end else if (take) begin
         grp_ff.kinds <= {3'(EV_NONE), grp_ff.kinds[2], grp_ff.kinds[1]};
         grp_ff.count <= grp_ff.count - 2'd1;
      end
   end

`ifndef NO_ASSERTIONS
   // A shown result group always holds at least one event.
   a_grp_count: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (grp_ff.count != 2'd0))
      else $error("result group valid with no events");

   // Taking a result that is not the last of its poll leaves more to show.
   a_tick_continues: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_data.last_of_tick) |=> rsp_valid)
      else $error("poll results cut short");

   // The cursor never leaves the effective screen.
   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, state_ff.cursor_col} < cfg.eff_width) &&
      ({1'b0, state_ff.cursor_row} < cfg.eff_height))
      else $error("cursor outside screen");

   // A poll moves into the result register only when that register is free.
   a_move_free: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && rsp_stall && in_valid_ff) |=> $stable(grp_ff))
      else $error("result group overwritten while stalled");
`endif

endmodule
